/* sv/i2cmq_pkg.sv */
// Shared types, constants and helpers for the I2C master message queue.
package i2cmq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_BUS  = 2'd2;

  localparam logic [7:0] STATUS_MASK = 8'hf8;
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RESTART  = 8'h10;
  localparam logic [7:0] ST_ADDR_W   = 8'h18;
  localparam logic [7:0] ST_DATA_W   = 8'h28;
  localparam logic [7:0] ST_ADDR_R   = 8'h40;
  localparam logic [7:0] ST_DATA_R   = 8'h58;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_TX      = 3'd3;
  localparam logic [2:0] ACT_CONT    = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_START = 2'd1;
  localparam logic [1:0] ERR_ADDR  = 2'd2;
  localparam logic [1:0] ERR_DATA  = 2'd3;

  localparam logic [7:0] POLL_ADDRESS_RESET = 8'h01;

  typedef enum logic [2:0] {
    PH_READY   = 3'd0,
    PH_START   = 3'd1,
    PH_STALE   = 3'd2,
    PH_ADDRESS = 3'd3,
    PH_DATA    = 3'd4
  } phase_t;

  typedef struct packed {
    logic capture;
    logic sel_head;
    logic latch_head;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

/* sv/i2cmq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module i2cmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/i2cmq_ctrl.sv */
// Controller state machine sequencing queue reads and command execution.
module i2cmq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  i2cmq_pkg::sts_t  sts,
  output i2cmq_pkg::ctl_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_NEXT = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_HEAD;
      end
      S_HEAD: state_next = S_NEXT;
      S_NEXT: state_next = S_EXEC;
      S_EXEC: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready       = (state == S_IDLE);
  assign ctl.capture    = (state == S_IDLE) && s_tvalid;
  assign ctl.sel_head   = (state == S_HEAD);
  assign ctl.latch_head = (state == S_NEXT);
  assign ctl.exec       = (state == S_EXEC) && !sts.out_busy;

endmodule

/* sv/i2cmq_dp.sv */
// Datapath: message queue, bus phase, sticky error, decision logic, output register.
module i2cmq_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       s_tuser,
  input  logic [31:0]      s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  i2cmq_pkg::ctl_t  ctl,
  output i2cmq_pkg::sts_t  sts
);

  localparam int PW = i2cmq_pkg::PTR_W;

  logic [1:0]  cmd;
  logic [7:0]  in_addr;
  logic [7:0]  in_data;
  logic [7:0]  in_status;
  logic [7:0]  in_rx;
  logic [7:0]  poll_address;
  logic [7:0]  head_addr;
  logic [7:0]  head_data;

  logic [PW-1:0] rp, rp_next;
  logic [PW-1:0] wp, wp_next;
  i2cmq_pkg::phase_t phase, phase_next;
  logic [1:0]  err, err_next;
  logic [7:0]  rdres, rdres_next;

  logic [PW-1:0] rd_addr;
  logic [PW-1:0] rp_inc;
  logic [7:0]  ram_addr_q;
  logic [7:0]  ram_data_q;
  logic        wr_addr_en;
  logic        wr_data_en;
  logic [7:0]  wr_addr_byte;

  logic        acc;
  logic [2:0]  act;
  logic [7:0]  tx;
  logic [7:0]  st;
  logic        is_read;
  logic        queue_open;

  assign rp_inc     = i2cmq_pkg::next_slot(rp);
  assign rd_addr    = ctl.sel_head ? rp : rp_inc;
  assign st         = in_status & i2cmq_pkg::STATUS_MASK;
  assign is_read    = head_addr[0];
  assign queue_open = (i2cmq_pkg::next_slot(wp) != rp);
  assign sts.out_busy = m_tvalid && !m_tready;

  i2cmq_ram #(.WIDTH(8), .DEPTH(i2cmq_pkg::QUEUE_DEPTH)) u_addr_ram (
    .clk     (clk),
    .wr_en   (wr_addr_en),
    .wr_addr (wp),
    .wr_data (wr_addr_byte),
    .rd_addr (rd_addr),
    .rd_data (ram_addr_q)
  );

  i2cmq_ram #(.WIDTH(8), .DEPTH(i2cmq_pkg::QUEUE_DEPTH)) u_data_ram (
    .clk     (clk),
    .wr_en   (wr_data_en),
    .wr_addr (wp),
    .wr_data (in_data),
    .rd_addr (rd_addr),
    .rd_data (ram_data_q)
  );

  always_comb begin
    rp_next      = rp;
    wp_next      = wp;
    phase_next   = phase;
    err_next     = err;
    rdres_next   = rdres;
    acc          = 1'b0;
    act          = i2cmq_pkg::ACT_NONE;
    tx           = 8'h00;
    wr_addr_en   = 1'b0;
    wr_data_en   = 1'b0;
    wr_addr_byte = in_addr;
    case (cmd)
      i2cmq_pkg::CMD_SEND: begin
        if (queue_open) begin
          wr_addr_en = ctl.exec;
          wr_data_en = ctl.exec;
          wp_next    = i2cmq_pkg::next_slot(wp);
          acc        = 1'b1;
          if (phase == i2cmq_pkg::PH_READY) begin
            phase_next = i2cmq_pkg::PH_START;
            act        = i2cmq_pkg::ACT_START;
          end
        end
      end
      i2cmq_pkg::CMD_TICK: begin
        wr_addr_byte = poll_address;
        if (queue_open) begin
          wr_addr_en = ctl.exec;
          wp_next    = i2cmq_pkg::next_slot(wp);
        end
        case (phase)
          i2cmq_pkg::PH_START: phase_next = i2cmq_pkg::PH_STALE;
          i2cmq_pkg::PH_STALE: act = i2cmq_pkg::ACT_RESTART;
          i2cmq_pkg::PH_READY: begin
            phase_next = i2cmq_pkg::PH_START;
            act        = i2cmq_pkg::ACT_START;
          end
          default: ;
        endcase
      end
      i2cmq_pkg::CMD_BUS: begin
        case (phase)
          i2cmq_pkg::PH_START, i2cmq_pkg::PH_STALE: begin
            if (st == i2cmq_pkg::ST_START || st == i2cmq_pkg::ST_RESTART) begin
              phase_next = i2cmq_pkg::PH_ADDRESS;
              act        = i2cmq_pkg::ACT_TX;
              tx         = head_addr;
            end else begin
              phase_next = i2cmq_pkg::PH_READY;
              err_next   = i2cmq_pkg::ERR_START;
              act        = i2cmq_pkg::ACT_STOP;
            end
          end
          i2cmq_pkg::PH_ADDRESS: begin
            if (is_read && st == i2cmq_pkg::ST_ADDR_R) begin
              phase_next = i2cmq_pkg::PH_DATA;
              act        = i2cmq_pkg::ACT_CONT;
            end else if (!is_read && st == i2cmq_pkg::ST_ADDR_W) begin
              phase_next = i2cmq_pkg::PH_DATA;
              act        = i2cmq_pkg::ACT_TX;
              tx         = head_data;
            end else begin
              phase_next = i2cmq_pkg::PH_READY;
              err_next   = i2cmq_pkg::ERR_ADDR;
              act        = i2cmq_pkg::ACT_STOP;
            end
          end
          i2cmq_pkg::PH_DATA: begin
            if ((is_read && st == i2cmq_pkg::ST_DATA_R) ||
                (!is_read && st == i2cmq_pkg::ST_DATA_W)) begin
              if (is_read) rdres_next = in_rx;
              rp_next = rp_inc;
              if (rp_inc != wp) begin
                // write to the same address as the next message: no restart
                if (!is_read && head_addr == ram_addr_q) begin
                  act = i2cmq_pkg::ACT_TX;
                  tx  = ram_data_q;
                end else begin
                  phase_next = i2cmq_pkg::PH_START;
                  act        = i2cmq_pkg::ACT_START;
                end
              end else begin
                phase_next = i2cmq_pkg::PH_READY;
                act        = i2cmq_pkg::ACT_STOP;
              end
            end else begin
              phase_next = i2cmq_pkg::PH_READY;
              err_next   = i2cmq_pkg::ERR_DATA;
              act        = i2cmq_pkg::ACT_STOP;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd       <= s_tuser;
      in_addr   <= s_tdata[7:0];
      in_data   <= s_tdata[15:8];
      in_status <= s_tdata[23:16];
      in_rx     <= s_tdata[31:24];
    end
    if (ctl.latch_head) begin
      head_addr <= ram_addr_q;
      head_data <= ram_data_q;
    end
    if (ctl.exec) begin
      m_tdata <= {7'd0, phase_next, rdres_next, err_next, tx, act, acc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp           <= '0;
      wp           <= '0;
      phase        <= i2cmq_pkg::PH_READY;
      err          <= i2cmq_pkg::ERR_NONE;
      rdres        <= 8'h00;
      poll_address <= i2cmq_pkg::POLL_ADDRESS_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) poll_address <= cfg_wr_data;
      if (ctl.exec) begin
        rp       <= rp_next;
        wp       <= wp_next;
        phase    <= phase_next;
        err      <= err_next;
        rdres    <= rdres_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* sv/i2c_master_message_queue_core.sv */
// Top level of the I2C master message queue sequencer.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in       | s_tvalid / s_tready | s_tuser: cmd; s_tdata: address, data,
//           |                     |   bus_status, bus_read_byte
//  out      | m_tvalid / m_tready | m_tdata: accepted, action, tx_byte,
//           |                     |   error_code, last_read, phase
//  config   | cfg_wr_en           | cfg_wr_data: poll_address
//
// Each transfer steps through accept, head read, next-entry read and execute;
// the single read port of the queue RAMs makes the two reads separate steps.
// The next transfer is accepted while the previous result still waits in m_tdata.
// Execute stalls while the output register is held by m_tready low.
// Reset is synchronous; the queue contents are not cleared.
module i2c_master_message_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,     // [1:0] cmd
  input  logic [31:0] s_tdata,     // [7:0] address, [15:8] data, [23:16] bus_status,
                                   // [31:24] bus_read_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // [0] accepted, [3:1] action, [11:4] tx_byte,
                                   // [13:12] error_code, [21:14] last_read,
                                   // [24:22] phase, [31:25] zero
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  i2cmq_pkg::ctl_t ctl;
  i2cmq_pkg::sts_t sts;

  i2cmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  i2cmq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .sts         (sts)
  );

endmodule

/* tb/i2c_master_message_queue_core_tb.sv */
// Self-checking testbench for the I2C master message queue core: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module i2c_master_message_queue_core_tb;
  import i2cmq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    logic       accepted;
    logic [2:0] action;
    logic [7:0] tx;
    logic [1:0] err;
    logic [7:0] last;
    phase_t     ph;
  } bus_reply_t;

  class bus_action_checker;
    logic [7:0] st_addr [QUEUE_DEPTH];
    logic [7:0] st_data [QUEUE_DEPTH];
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [PTR_W-1:0] wr_ptr = '0;
    phase_t     ph = PH_READY;
    logic [1:0] err = ERR_NONE;
    logic [7:0] last_rd = 8'h00;
    logic [7:0] poll = POLL_ADDRESS_RESET;
    bus_reply_t pending_replies[$];
    int n_bad = 0;
    int n_checked = 0;
    int n_refused = 0;
    int n_merged = 0;
    int n_fail = 0;
    int n_polls = 0;

    function logic [PTR_W-1:0] advance_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // apply one accepted input transfer and queue the reply it must produce
    function void accept_item(input logic [1:0] cmd, input logic [31:0] d);
      bus_reply_t r;
      logic [7:0] stat;
      logic [7:0] head;
      logic is_rd;
      logic [PTR_W-1:0] nxt;
      stat = d[23:16] & STATUS_MASK;
      r.accepted = 1'b0;
      r.action = ACT_NONE;
      r.tx = 8'h00;
      nxt = advance_slot(wr_ptr);
      case (cmd)
        CMD_SEND: begin
          if (nxt != rd_ptr) begin
            st_addr[wr_ptr] = d[7:0];
            st_data[wr_ptr] = d[15:8];
            wr_ptr = nxt;
            r.accepted = 1'b1;
            if (ph == PH_READY) begin
              ph = PH_START;
              r.action = ACT_START;
            end
          end else begin
            n_refused++;
          end
        end
        CMD_TICK: begin
          if (nxt != rd_ptr) begin
            st_addr[wr_ptr] = poll;
            wr_ptr = nxt;
            n_polls++;
          end
          if (ph == PH_START) begin
            ph = PH_STALE;
          end else if (ph == PH_STALE) begin
            r.action = ACT_RESTART;
          end else if (ph == PH_READY) begin
            ph = PH_START;
            r.action = ACT_START;
          end
        end
        CMD_BUS: begin
          head = st_addr[rd_ptr];
          is_rd = head[0];
          case (ph)
            PH_START, PH_STALE: begin
              if (stat == ST_START || stat == ST_RESTART) begin
                ph = PH_ADDRESS;
                r.action = ACT_TX;
                r.tx = head;
              end else begin
                ph = PH_READY;
                err = ERR_START;
                r.action = ACT_STOP;
                n_fail++;
              end
            end
            PH_ADDRESS: begin
              if (is_rd && stat == ST_ADDR_R) begin
                ph = PH_DATA;
                r.action = ACT_CONT;
              end else if (!is_rd && stat == ST_ADDR_W) begin
                ph = PH_DATA;
                r.action = ACT_TX;
                r.tx = st_data[rd_ptr];
              end else begin
                ph = PH_READY;
                err = ERR_ADDR;
                r.action = ACT_STOP;
                n_fail++;
              end
            end
            PH_DATA: begin
              if ((is_rd && stat == ST_DATA_R) || (!is_rd && stat == ST_DATA_W)) begin
                if (is_rd) last_rd = d[31:24];
                rd_ptr = advance_slot(rd_ptr);
                if (rd_ptr != wr_ptr) begin
                  if (!is_rd && head == st_addr[rd_ptr]) begin
                    r.action = ACT_TX;
                    r.tx = st_data[rd_ptr];
                    n_merged++;
                  end else begin
                    ph = PH_START;
                    r.action = ACT_START;
                  end
                end else begin
                  ph = PH_READY;
                  r.action = ACT_STOP;
                end
              end else begin
                ph = PH_READY;
                err = ERR_DATA;
                r.action = ACT_STOP;
                n_fail++;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.err = err;
      r.last = last_rd;
      r.ph = ph;
      pending_replies.push_back(r);
    endfunction

    function void check_result(input logic [31:0] m);
      bus_reply_t r;
      if (pending_replies.size() == 0) begin
        if (n_bad < 10) $display("result %h arrived with nothing pending", m);
        n_bad++;
        return;
      end
      r = pending_replies.pop_front();
      n_checked++;
      if (m[0] !== r.accepted || m[3:1] !== r.action || m[11:4] !== r.tx ||
          m[13:12] !== r.err || m[21:14] !== r.last || m[24:22] !== r.ph ||
          m[31:25] !== 7'd0) begin
        if (n_bad < 10) begin
          $write("mismatch #%0d: acc %b/%b act %0d/%0d tx %h/%h ", n_checked,
                 m[0], r.accepted, m[3:1], r.action, m[11:4], r.tx);
          $display("err %0d/%0d last %h/%h ph %0d/%0d pad %h (got/exp)",
                   m[13:12], r.err, m[21:14], r.last, m[24:22], r.ph, m[31:25]);
        end
        n_bad++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [1:0]  s_tuser;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  int tx_idle = 31;
  int rx_idle = 80;
  int cycles = 0;
  int n_items = 0;

  bus_action_checker sb = new();

  i2c_master_message_queue_core dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies pending", cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic push(input logic [1:0] c, input logic [31:0] d);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = c;
    s_tdata = d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.accept_item(c, d);
    n_items++;
  endtask

  task automatic put(input logic [1:0] c, input logic [7:0] a, input logic [7:0] dt,
                     input logic [7:0] st, input logic [7:0] rx);
    push(c, {rx, st, dt, a});
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_poll(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.poll = v;
  endtask

  // fill the queue to capacity (QUEUE_DEPTH - 1 entries), then the special cases
  task automatic directed();
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) put(CMD_SEND, 8'ha0, 8'(i), 8'h00, 8'h00);
    put(CMD_SEND, 8'h33, 8'hff, 8'h00, 8'h00);
    put(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    put(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    put(CMD_BUS, 8'hff, 8'hff, ST_RESTART | 8'h07, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_ADDR_W, 8'h00);
    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
      put(CMD_BUS, 8'h00, 8'h00, ST_DATA_W | 8'(i & 7), 8'h00);
    put(CMD_SEND, 8'hff, 8'hff, 8'h00, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, 8'h00, 8'h00);
    put(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_START, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_ADDR_R, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_DATA_R, 8'hff);
    put(CMD_BUS, 8'h00, 8'h00, ST_START, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_ADDR_W, 8'h00);
    put(CMD_BUS, 8'hff, 8'hff, 8'hff, 8'hff);
    put(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
    put(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_START, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_ADDR_R, 8'h00);
    put(CMD_BUS, 8'h00, 8'h00, ST_DATA_W, 8'h00);
    put(CMD_SEND, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // mostly the status the current phase expects, so messages run to completion
  task automatic make_item(output logic [1:0] c, output logic [31:0] d);
    int r;
    logic [7:0] a, dt, st, rx;
    logic rd;
    a = 8'($urandom);
    dt = 8'($urandom);
    st = 8'($urandom);
    rx = 8'($urandom);
    r = $urandom_range(99);
    c = (r < 16) ? CMD_SEND : (r < 24) ? CMD_TICK : (r < 97) ? CMD_BUS : CMD_UNUSED;
    if (c == CMD_BUS && sb.ph == PH_READY && $urandom_range(3) != 0) c = CMD_SEND;
    if ($urandom_range(9) < 6) a = 8'h50 | 8'($urandom_range(3));
    rd = sb.st_addr[sb.rd_ptr][0];
    if ($urandom_range(99) < 90 && sb.ph != PH_READY) begin
      case (sb.ph)
        PH_START, PH_STALE: st = $urandom_range(1) ? ST_START : ST_RESTART;
        PH_ADDRESS:         st = rd ? ST_ADDR_R : ST_ADDR_W;
        PH_DATA:            st = rd ? ST_DATA_R : ST_DATA_W;
        default: ;
      endcase
      st = st | 8'($urandom_range(7));
    end
    d = {rx, st, dt, a};
  endtask

  task automatic random_run(input int target);
    logic [1:0] c;
    logic [31:0] d;
    for (int k = 0; k < target; k++) begin
      make_item(c, d);
      push(c, d);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 2'd0;
    s_tdata = 32'd0;
    m_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed();
    settle();
    write_poll(8'h00);
    random_run(ITEMS_PER_PHASE);
    settle();

    tx_idle = 80;
    rx_idle = 31;
    write_poll(8'hff);
    random_run(ITEMS_PER_PHASE);
    settle();

    tx_idle = 0;
    rx_idle = 0;
    write_poll(8'($urandom));
    random_run(ITEMS_PER_PHASE);
    settle();
    repeat (12) @(posedge clk);

    $display("%0d transfers in, %0d results checked, %0d mismatches",
             n_items, sb.n_checked, sb.n_bad);
    $display("refused sends %0d, polls queued %0d, merged writes %0d, bus failures %0d",
             sb.n_refused, sb.n_polls, sb.n_merged, sb.n_fail);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
